// ===== hdl/efm_pkg.sv =====
package efm_pkg;

  // Counter width; the design holds for 8 to 48.
  localparam int COUNT_BITS = 32;

  localparam int TIME_W = 32;
  localparam int FREQ_W = 42;

  // ticks * 1000 needs ten more bits than the counter.
  localparam int DIV_W  = COUNT_BITS + 10;
  localparam int STEP_W = $clog2(DIV_W + 1);
  localparam int EXT_W  = (DIV_W > FREQ_W) ? DIV_W : FREQ_W;

  // Operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_MEASURE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NO_TIME  = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TIME_W-1:0] now_ms;
  } efm_in_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency_hz;
    logic [1:0]        status;
  } efm_out_t;

endpackage

// ===== hdl/event_frequency_meter.sv =====
// Gated frequency counter.
//
// Input channel (in_valid/in_ready/in_data) carries one operation per
// transaction: a tick event, a window restart, or a measure request. Restart
// and measure carry the current time in ms. Ticks and restarts complete in the
// cycle they are accepted, so between measures ticks stream at one per cycle.
//
// A measure returns one transaction on the output channel (out_valid/
// out_ready/out_data): ticks * 1000 / elapsed_ms, or zero with a failure status
// on counter overflow or zero elapsed time. The window restarts at the measure
// time either way. The quotient comes from one shared restoring divider that
// retires one quotient bit per cycle in S_DIV; a measure holds in_ready low
// through S_DIV and S_DONE, and out_valid is registered from S_DONE once the
// output register is free. Failing measures skip the divider and go from
// acceptance straight to S_DONE.
//
// The output register decouples the channels: ticks and restarts keep being
// accepted while a result waits. A finished measure waits in the done state,
// with in_ready low, until the output register frees up.
// Reset clears the count, the overflow flag, the window start and out_valid.
module event_frequency_meter
  import efm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  efm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output efm_out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_t state_r, state_nxt;

  // Window state
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [TIME_W-1:0]     start_r, start_nxt;
  logic                  ovf_r, ovf_nxt;

  // Divider: quo_r shifts the dividend out and the quotient in
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] den_r, den_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        status_r, status_nxt;

  logic     out_valid_r, out_valid_nxt;
  efm_out_t out_data_r, out_data_nxt;

  logic                  accept;
  logic [TIME_W-1:0]     elapsed;
  logic [DIV_W-1:0]      cnt_ext;
  logic [DIV_W-1:0]      product;
  logic [COUNT_BITS-1:0] count_inc;
  logic [TIME_W:0]       rem_sh;
  logic [TIME_W+1:0]     diff;
  logic [EXT_W-1:0]      quo_ext;
  logic [FREQ_W-1:0]     freq;
  logic                  out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign elapsed = in_data.now_ms - start_r;

  // ticks * 1000 as (t << 10) - (t << 4) - (t << 3); exact in DIV_W bits
  assign cnt_ext = DIV_W'(count_r);
  assign product = (cnt_ext << 10) - (cnt_ext << 4) - (cnt_ext << 3);

  assign count_inc = count_r + COUNT_BITS'(1);

  // One restoring division step
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};

  // Saturate to the output field when the quotient can be wider
  assign quo_ext = EXT_W'(quo_r);
  assign freq    = (|(quo_ext >> FREQ_W)) ? '1 : quo_ext[FREQ_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    start_nxt     = start_r;
    ovf_nxt       = ovf_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    step_nxt      = step_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_TICK: begin
              // count holds at max; flag is sticky
              if (count_r != COUNT_MAX) begin
                count_nxt = count_inc;
              end
              if (count_r == COUNT_MAX || count_inc == COUNT_MAX) begin
                ovf_nxt = 1'b1;
              end
            end
            OP_RESTART: begin
              count_nxt = '0;
              start_nxt = in_data.now_ms;
              ovf_nxt   = 1'b0;
            end
            OP_MEASURE: begin
              count_nxt = '0;
              start_nxt = in_data.now_ms;
              ovf_nxt   = 1'b0;
              rem_nxt   = '0;
              den_nxt   = elapsed;
              step_nxt  = STEP_W'(DIV_W);
              if (ovf_r) begin
                status_nxt = ST_OVERFLOW;
                quo_nxt    = '0;
                state_nxt  = S_DONE;
              end else if (elapsed == '0) begin
                status_nxt = ST_NO_TIME;
                quo_nxt    = '0;
                state_nxt  = S_DONE;
              end else begin
                status_nxt = ST_OK;
                quo_nxt    = product;
                state_nxt  = S_DIV;
              end
            end
            default: ;  // unused code: ignored
          endcase
        end
      end
      S_DIV: begin
        if (!diff[TIME_W+1]) begin
          rem_nxt = diff[TIME_W-1:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[TIME_W-1:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.frequency_hz = freq;
          out_data_nxt.status       = status_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      start_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    step_r     <= step_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/efm_checker.sv =====
module efm_checker
  import efm_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input efm_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input efm_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // ticks stream back to back
  a_tick_streams: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_TICK |=> in_ready)
    else $error("tick stalled the input");

  a_measure_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_MEASURE |=> !in_ready)
    else $error("input open during measure");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.frequency_hz == '0)
    else $error("failed measure with nonzero frequency");

endmodule

bind event_frequency_meter efm_checker u_efm_checker (.*);

// ===== tb/event_frequency_meter_test.sv =====
`timescale 1ns / 100ps

// Transaction-level check of the gated frequency counter.
// Every transaction accepted on the input channel is run through a local
// predictor of the counter. Each measure pushes the frequency/status it should
// produce, and the output monitor pops and compares them in order.
module event_frequency_meter_test;
  import efm_pkg::*;

  // Operation code 3 has no meaning; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [63:0] MS_PER_S = 64'd1000;
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;
  localparam logic [63:0] FREQ_FULL = (64'd1 << FREQ_W) - 64'd1;

  // Allowance for a measure through the divider, from acceptance to result.
  localparam int MEASURE_LAT = DIV_W + 2;
  // Cycles with no transaction on either channel before the run is abandoned.
  // Worst case is a measure stuck in the done state behind a long receiver stall.
  localparam int QUIET_LIMIT = 4000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  efm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  efm_out_t out_data;

  event_frequency_meter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Predictor state, matching the block's reset values.
  logic [COUNT_BITS-1:0] ticks_seen = '0;
  logic [TIME_W-1:0]     window_open_ms = '0;
  logic                  count_saturated = 1'b0;

  efm_out_t    results_due[$];
  efm_out_t    result_want;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  int          sender_idle_pct = 20;
  int          receiver_idle_pct = 68;

  // Opening script. Rows with pinned set carry a result worked out by hand;
  // other measure rows are checked against the predictor.
  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] now;
    logic              pinned;
    logic [FREQ_W-1:0] freq;
    logic [1:0]        status;
  } script_row_t;

  localparam int SCRIPT_LEN = 24;

  script_row_t opening_script [SCRIPT_LEN] = '{
    // window opened at 0 by reset: no time has passed
    '{OP_MEASURE, 32'h0000_0000, 1'b1, 42'd0,    ST_NO_TIME},
    // one ms, no ticks: a valid zero
    '{OP_MEASURE, 32'h0000_0001, 1'b1, 42'd0,    ST_OK},
    // ticks carry junk time that must be ignored
    '{OP_TICK,    32'hFFFF_FFFF, 1'b0, 42'd0,    ST_OK},
    '{OP_TICK,    32'h0000_0000, 1'b0, 42'd0,    ST_OK},
    '{OP_TICK,    32'hAAAA_AAAA, 1'b0, 42'd0,    ST_OK},
    // three ticks over three ms
    '{OP_MEASURE, 32'h0000_0004, 1'b1, 42'd1000, ST_OK},
    // window start at the top of the time range, then wrap to zero
    '{OP_RESTART, 32'hFFFF_FFFF, 1'b0, 42'd0,    ST_OK},
    '{OP_TICK,    32'h5555_5555, 1'b0, 42'd0,    ST_OK},
    '{OP_MEASURE, 32'h0000_0000, 1'b1, 42'd1000, ST_OK},
    // unused code: no state change, so the next measure sees no time
    '{OP_UNUSED,  32'hFFFF_FFFF, 1'b0, 42'd0,    ST_OK},
    '{OP_MEASURE, 32'h0000_0000, 1'b1, 42'd0,    ST_NO_TIME},
    // longest possible window rounds down to zero
    '{OP_TICK,    32'h0000_0000, 1'b0, 42'd0,    ST_OK},
    '{OP_TICK,    32'h0000_0000, 1'b0, 42'd0,    ST_OK},
    '{OP_MEASURE, 32'hFFFF_FFFF, 1'b1, 42'd0,    ST_OK},
    '{OP_RESTART, 32'h5555_5555, 1'b0, 42'd0,    ST_OK},
    '{OP_TICK,    32'h0000_0000, 1'b0, 42'd0,    ST_OK},
    '{OP_MEASURE, 32'hAAAA_AAAA, 1'b0, 42'd0,    ST_OK},
    '{OP_RESTART, 32'h1234_5678, 1'b0, 42'd0,    ST_OK},
    '{OP_TICK,    32'h0000_0000, 1'b0, 42'd0,    ST_OK},
    '{OP_TICK,    32'h0000_0000, 1'b0, 42'd0,    ST_OK},
    '{OP_MEASURE, 32'h1234_567F, 1'b0, 42'd0,    ST_OK},
    // restart then measure at the same time
    '{OP_RESTART, 32'h8000_0000, 1'b0, 42'd0,    ST_OK},
    '{OP_MEASURE, 32'h8000_0000, 1'b1, 42'd0,    ST_NO_TIME},
    '{OP_MEASURE, 32'h8000_0001, 1'b1, 42'd0,    ST_OK}
  };

  // Predictor: applies one transaction to the local copy of the counter and
  // returns 1 with the frequency/status when it is a measure.
  // Saturation needs 2^COUNT_BITS - 1 ticks, so the overflow path only shows
  // up here when the package is built with a narrow counter.
  function automatic logic meter_step(input efm_in_t item, output efm_out_t res);
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       quotient;
    res = '0;
    meter_step = 1'b0;
    case (item.operation)
      OP_TICK: begin
        if (ticks_seen != COUNT_FULL) ticks_seen = ticks_seen + 1'b1;
        if (ticks_seen == COUNT_FULL) count_saturated = 1'b1;
      end
      OP_RESTART: begin
        ticks_seen      = '0;
        window_open_ms  = item.now_ms;
        count_saturated = 1'b0;
      end
      OP_MEASURE: begin
        elapsed = item.now_ms - window_open_ms;   // wraps mod 2^32
        if (count_saturated) begin
          res.status = ST_OVERFLOW;               // overflow beats zero time
        end else if (elapsed == '0) begin
          res.status = ST_NO_TIME;
        end else begin
          quotient = (64'(ticks_seen) * MS_PER_S) / 64'(elapsed);
          if (quotient > FREQ_FULL) quotient = FREQ_FULL;
          res.frequency_hz = quotient[FREQ_W-1:0];
          res.status       = ST_OK;
        end
        // the window restarts whether or not the measure failed
        ticks_seen      = '0;
        window_open_ms  = item.now_ms;
        count_saturated = 1'b0;
        meter_step = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Drive one input transaction and wait for it to be taken. Valid only drops
  // when the sender decides to idle, so back-to-back transactions stream.
  task automatic send(input efm_in_t item, input logic pinned, input efm_out_t pinned_res);
    efm_out_t res;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (meter_step(item, res)) results_due.push_back(pinned ? pinned_res : res);
    if (item.operation != OP_UNUSED) items_sent++;
  endtask

  // Hold the sender off until every pending measure has reported.
  // It always drops valid before returning, even when nothing is pending.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // Mostly well-formed windows: optional restart, a burst of ticks, then a
  // measure at a chosen distance. The rest is junk: random codes and times.
  task automatic random_phase(input int unsigned budget);
    int unsigned       stop_at;
    int unsigned       burst;
    logic [TIME_W-1:0] base;
    efm_in_t           item;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          item.operation = 2'($urandom_range(3));
          item.now_ms    = $urandom();
          send(item, 1'b0, '0);
        end
      end else begin
        base = window_open_ms;   // chained window when no restart follows
        if ($urandom_range(9) < 7) begin
          base = $urandom();
          item.operation = OP_RESTART;
          item.now_ms    = base;
          send(item, 1'b0, '0);
        end
        burst = ($urandom_range(7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
        repeat (burst) begin
          item.operation = OP_TICK;
          item.now_ms    = $urandom();
          send(item, 1'b0, '0);
        end
        item.operation = OP_MEASURE;
        case ($urandom_range(3))
          0: item.now_ms = base;
          1: item.now_ms = base + $urandom_range(1, 16);
          2: item.now_ms = base + $urandom_range(1, 100000);
          default: item.now_ms = base + $urandom();
        endcase
        send(item, 1'b0, '0);
      end
      if ($urandom_range(29) == 0) drain();
    end
  endtask

  // Receiver backpressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Result monitor: each result against the oldest pending prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: frequency_hz %0d status %0d",
                 $time, out_data.frequency_hz, out_data.status);
      end else begin
        result_want = results_due.pop_front();
        if (out_data.frequency_hz !== result_want.frequency_hz) begin
          errors++;
          $display("%0t: frequency_hz expected %0d, actual %0d",
                   $time, result_want.frequency_hz, out_data.frequency_hz);
        end
        if (out_data.status !== result_want.status) begin
          errors++;
          $display("%0t: status expected %0d, actual %0d",
                   $time, result_want.status, out_data.status);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    efm_in_t  item;
    efm_out_t fixed;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender idles a little, receiver a lot
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      item.operation     = opening_script[i].op;
      item.now_ms        = opening_script[i].now;
      fixed.frequency_hz = opening_script[i].freq;
      fixed.status       = opening_script[i].status;
      send(item, opening_script[i].pinned, fixed);
    end
    random_phase(620);
    drain();

    // phase 2: roles swapped
    sender_idle_pct = 68;
    receiver_idle_pct <= 20;
    random_phase(650);
    drain();

    // phase 3: full rate on both sides
    sender_idle_pct = 0;
    receiver_idle_pct <= 0;
    random_phase(650);
    drain();

    repeat (MEASURE_LAT + 8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
